### rtl/rat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rat_pkg;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned KindWidth  = 3;

  localparam logic [KindWidth-1:0] KindLoad = 3'd0;
  localparam logic [KindWidth-1:0] KindAdd  = 3'd1;
  localparam logic [KindWidth-1:0] KindSub  = 3'd2;
  localparam logic [KindWidth-1:0] KindMul  = 3'd3;
  localparam logic [KindWidth-1:0] KindDiv  = 3'd4;

  // Requests from the sequencer to the shared unit.
  typedef struct packed {
    logic start_div;  // begin a restoring division of the shared registers
  } unit_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;
endpackage
`default_nettype wire

### rtl/rat_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rat_in_if #(
  parameter int unsigned ValueWidth = rat_pkg::ValueWidth
);
  logic                               valid;
  logic                               ready;
  logic [rat_pkg::KindWidth-1:0]      kind;
  logic signed [ValueWidth-1:0]       operand_num;
  logic signed [ValueWidth-1:0]       operand_den;
  modport source (output valid, kind, operand_num, operand_den, input ready);
  modport sink (input valid, kind, operand_num, operand_den, output ready);
endinterface

interface rat_out_if #(
  parameter int unsigned ValueWidth = rat_pkg::ValueWidth
);
  logic                         valid;
  logic                         ready;
  logic signed [ValueWidth-1:0] value_num;
  logic [ValueWidth-2:0]        value_den;
  logic                         error;
  modport source (output valid, value_num, value_den, error, input ready);
  modport sink (input valid, value_num, value_den, error, output ready);
endinterface
`default_nettype wire

### rtl/rat_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared restoring divider: one quotient bit a cycle over a 2W-bit dividend.
module rat_div #(
  parameter int unsigned ValueWidth = rat_pkg::ValueWidth
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire rat_pkg::unit_ctrl_t   ctrl_i,
  input  wire  [2*ValueWidth-1:0]    dividend_i,
  input  wire  [2*ValueWidth-1:0]    divisor_i,
  output rat_pkg::unit_stat_t        stat_o,
  output logic [2*ValueWidth-1:0]    quot_o,
  output logic [2*ValueWidth-1:0]    rem_o
);
  localparam int unsigned DW = 2 * ValueWidth;
  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] quot_q, quot_d, rem_q, rem_d, dsr_q, dsr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [DW:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[DW-1]} - {1'b0, dsr_q};
    if (ctrl_i.start_div) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = CW'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial[DW]) begin
        rem_d = {rem_q[DW-2:0], quot_q[DW-1]};
        quot_d = {quot_q[DW-2:0], 1'b0};
      end else begin
        rem_d = trial[DW-1:0];
        quot_d = {quot_q[DW-2:0], 1'b1};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

`ifndef ASSERT_OFF
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.done |-> $past(busy_q)) else $error("done without busy");
  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.done |-> !busy_q || $past(ctrl_i.start_div)) else $error("busy after done");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start_div |=> busy_q) else $error("start did not take");
`endif
endmodule
`default_nettype wire

### rtl/rational_accumulator_alu.sv
// Channel   Dir  Fields                              Handshake
// in_i      in   kind, operand_num, operand_den      valid/ready
// out_o     out  value_num, value_den, error         valid/ready
//
// One item at a time. Products are formed in turn on a single
// W x W multiplier; the gcd is the Euclidean loop on a shared 2W-bit
// restoring divider, then two more divisions by the gcd. The time an
// item takes is set by the number of Euclid steps. Reset gives 0/1. A
// stalled result holds in the output register; no new item is taken
// until it leaves.
`timescale 1ns / 1ps
`default_nettype none
module rational_accumulator_alu #(
  parameter int unsigned ValueWidth = rat_pkg::ValueWidth
) (
  input wire       clk_i,
  input wire       rst_ni,
  rat_in_if.sink   in_i,
  rat_out_if.source out_o
);
  localparam int unsigned W  = ValueWidth;
  localparam int unsigned DW = 2 * W;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StP0   = 4'd1;
  localparam logic [3:0] StP1   = 4'd2;
  localparam logic [3:0] StP2   = 4'd3;
  localparam logic [3:0] StSum  = 4'd4;
  localparam logic [3:0] StGcd  = 4'd5;
  localparam logic [3:0] StGwt  = 4'd6;
  localparam logic [3:0] StDn   = 4'd7;
  localparam logic [3:0] StDnW  = 4'd8;
  localparam logic [3:0] StDd   = 4'd9;
  localparam logic [3:0] StDdW  = 4'd10;
  localparam logic [3:0] StFin  = 4'd11;
  localparam logic [3:0] StOut  = 4'd12;

  logic [3:0] st_q, st_d;
  logic signed [W-1:0] acc_num_q, acc_num_d;
  logic [W-2:0] acc_den_q, acc_den_d;
  logic err_q, err_d;
  logic [rat_pkg::KindWidth-1:0] kind_q, kind_d;
  logic on_neg_q, on_neg_d, od_neg_q, od_neg_d;
  logic [W-1:0] on_q, on_d, od_q, od_d;
  logic [DW-1:0] x_q, x_d, y_q, y_d, t_q, t_d;
  logic xn_q, xn_d, tn_q, tn_d, yn_q, yn_d;
  logic [DW-1:0] ga_q, ga_d, gb_q, gb_d, nm_q, nm_d;

  // Single shared multiplier.
  logic [W-1:0]  ma, mb;
  logic [DW-1:0] mp;
  assign mp = DW'(ma) * DW'(mb);

  rat_pkg::unit_ctrl_t uc;
  rat_pkg::unit_stat_t us;
  logic [DW-1:0] dvd, dvs, quot, rem;

  rat_div #(.ValueWidth(W)) u_div (
    .clk_i, .rst_ni, .ctrl_i(uc), .dividend_i(dvd), .divisor_i(dvs),
    .stat_o(us), .quot_o(quot), .rem_o(rem)
  );

  logic [W-1:0] an_mag;
  logic an_neg, wr_neg, okay;
  logic [DW-1:0] lim;
  assign an_neg = acc_num_q[W-1];
  assign an_mag = an_neg ? W'(-acc_num_q) : W'(acc_num_q);
  assign lim = DW'(1) << (W - 1);

  always_comb begin
    st_d = st_q; acc_num_d = acc_num_q; acc_den_d = acc_den_q; err_d = err_q;
    kind_d = kind_q; on_neg_d = on_neg_q; od_neg_d = od_neg_q;
    on_d = on_q; od_d = od_q; x_d = x_q; y_d = y_q; t_d = t_q;
    xn_d = xn_q; tn_d = tn_q; yn_d = yn_q;
    ga_d = ga_q; gb_d = gb_q; nm_d = nm_q;
    ma = an_mag; mb = od_q;
    uc.start_div = 1'b0; dvd = ga_q; dvs = gb_q;
    wr_neg = 1'b0; okay = 1'b0;
    case (st_q)
      StIdle: begin
        if (in_i.valid) begin
          kind_d   = in_i.kind;
          on_neg_d = in_i.operand_num[W-1];
          od_neg_d = in_i.operand_den[W-1];
          on_d = in_i.operand_num[W-1] ? W'(-in_i.operand_num) : W'(in_i.operand_num);
          od_d = in_i.operand_den[W-1] ? W'(-in_i.operand_den) : W'(in_i.operand_den);
          st_d = StP0;
        end
      end
      StP0: begin
        // x: numerator, y: denominator.
        case (kind_q)
          rat_pkg::KindLoad: begin
            x_d = DW'(on_q); xn_d = on_neg_q; y_d = DW'(od_q); yn_d = od_neg_q;
            st_d = StSum;
          end
          rat_pkg::KindAdd, rat_pkg::KindSub, rat_pkg::KindDiv: begin
            ma = an_mag; mb = od_q; x_d = mp; xn_d = an_neg ^ od_neg_q;
            st_d = StP1;
          end
          rat_pkg::KindMul: begin
            ma = an_mag; mb = on_q; x_d = mp; xn_d = an_neg ^ on_neg_q;
            st_d = StP1;
          end
          default: begin
            err_d = 1'b1; st_d = StOut;
          end
        endcase
      end
      StP1: begin
        ma = W'(acc_den_q);
        mb = (kind_q == rat_pkg::KindDiv) ? on_q : od_q;
        y_d = mp;
        yn_d = (kind_q == rat_pkg::KindDiv) ? on_neg_q : od_neg_q;
        st_d = (kind_q == rat_pkg::KindAdd || kind_q == rat_pkg::KindSub) ? StP2 : StSum;
      end
      StP2: begin
        ma = on_q; mb = W'(acc_den_q); t_d = mp;
        tn_d = on_neg_q ^ (kind_q == rat_pkg::KindSub);
        st_d = StSum;
      end
      StSum: begin
        if (kind_q == rat_pkg::KindAdd || kind_q == rat_pkg::KindSub) begin
          if (xn_q == tn_q) x_d = x_q + t_q;
          else if (x_q >= t_q) x_d = x_q - t_q;
          else begin
            x_d = t_q - x_q; xn_d = tn_q;
          end
        end
        ga_d = (kind_q == rat_pkg::KindAdd || kind_q == rat_pkg::KindSub) ? x_d : x_q;
        gb_d = y_q;
        if (y_q == '0) begin
          err_d = 1'b1; st_d = StOut;
        end else begin
          err_d = 1'b0; st_d = StGcd;
        end
      end
      StGcd: begin
        if (gb_q == '0) st_d = StDn;
        else begin
          uc.start_div = 1'b1; st_d = StGwt;
        end
      end
      StGwt: begin
        if (us.done) begin
          ga_d = gb_q; gb_d = rem; st_d = StGcd;
        end
      end
      StDn: begin
        dvd = x_q; dvs = ga_q; uc.start_div = 1'b1; st_d = StDnW;
      end
      StDnW: begin
        if (us.done) begin
          nm_d = quot; st_d = StDd;
        end
      end
      StDd: begin
        dvd = y_q; dvs = ga_q; uc.start_div = 1'b1; st_d = StDdW;
      end
      StDdW: begin
        if (us.done) begin
          y_d = quot; st_d = StFin;
        end
      end
      StFin: begin
        wr_neg = (nm_q != '0) && (xn_q != yn_q);
        okay = (y_q <= lim - DW'(1)) && (wr_neg ? nm_q <= lim : nm_q <= lim - DW'(1));
        if (okay) begin
          acc_num_d = wr_neg ? W'(-nm_q) : W'(nm_q);
          acc_den_d = (W-1)'(y_q);
        end else err_d = 1'b1;
        st_d = StOut;
      end
      StOut: begin
        if (out_o.ready) st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      acc_num_q <= '0;
      acc_den_q <= (W-1)'(1);
      err_q <= 1'b0;
    end else begin
      st_q <= st_d;
      acc_num_q <= acc_num_d;
      acc_den_q <= acc_den_d;
      err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d; on_neg_q <= on_neg_d; od_neg_q <= od_neg_d;
    on_q <= on_d; od_q <= od_d; x_q <= x_d; y_q <= y_d; t_q <= t_d;
    xn_q <= xn_d; tn_q <= tn_d; yn_q <= yn_d;
    ga_q <= ga_d; gb_q <= gb_d; nm_q <= nm_d;
  end

  assign in_i.ready     = (st_q == StIdle);
  assign out_o.valid    = (st_q == StOut);
  assign out_o.value_num = acc_num_q;
  assign out_o.value_den = acc_den_q;
  assign out_o.error    = err_q;

`ifndef ASSERT_OFF
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_den_q != '0) else $error("zero denominator stored");
  a_zero_is_canon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_num_q == '0 |-> acc_den_q == (W-1)'(1)) else $error("zero not 0/1");
  a_error_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StFin && !okay) |=> $stable(acc_num_q) && $stable(acc_den_q))
    else $error("state changed on error");
  a_no_div_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StIdle |-> !us.busy) else $error("divider busy while idle");
`endif
endmodule
`default_nettype wire
